// File: hw/rtl/pec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_pkg: shared types, constants and helpers of the polarization correction
// Widths of the fixed-point formats, register map, latencies and the rounded
// Q.19 multiply used by the efficiency mixing stages.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int POLY_TERMS_DEF = 3;
  localparam int POLY_MAX       = 3;

  localparam int COEF_W   = 21;   // one packed Q2.19 coefficient
  localparam int CREG_W   = COEF_W * POLY_MAX;
  localparam int EFF_W    = 21;   // saturated efficiency, Q2.19
  localparam int EFF_FRAC = 19;
  localparam int WL_W     = 24;   // wavelength, Q6.18
  localparam int WL_FRAC  = 18;
  localparam int INT_W    = 32;   // intensities, Q16.16
  localparam int ST_W     = 2;
  localparam int MW       = 32;   // mixing arithmetic width
  localparam int NUM_W    = 64;   // numerator width
  localparam int QBITS    = 33;   // quotient bits produced by the divider
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int NCH      = 4;

  localparam logic signed [MW-1:0] ONE = 32'sd524288;
  localparam logic [CREG_W-1:0] COEF_RESET = 63'd524288;

  // register indexes (paddr[5:3])
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_RHO   = 3'd1;
  localparam logic [2:0] REG_PP    = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;
  localparam logic [2:0] REG_AP    = 3'd4;

  // efficiency slots in the coefficient bank
  localparam int E_RHO   = 0;
  localparam int E_PP    = 1;
  localparam int E_ALPHA = 2;
  localparam int E_AP    = 3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

  localparam int EFF_LAT    = 4;
  localparam int MIX_LAT    = 4;
  localparam int DIV_LAT    = QBITS + 1;
  localparam int IDLY       = EFF_LAT + MIX_LAT;
  localparam int SIDE_LAT   = 3 + DIV_LAT;
  localparam int PIPE_DEPTH = 1 + EFF_LAT + MIX_LAT + 3 + DIV_LAT + 1;

  typedef struct packed {
    logic                          refl;
    logic [NCH-1:0][CREG_W-1:0]    coef;
  } cfg_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } side_t;

  // Q.19 product, rounded half up
  function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = (2*MW)'(a) * (2*MW)'(b);
    p = p + 64'sd262144;
    p = p >>> EFF_FRAC;
    mulq = $signed(p[MW-1:0]);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pec_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_in_if: input bin channel
// Wavelength and four measured intensities of one bin, valid/ready transfer.
// ----------------------------------------------------------------------------
interface pec_in_if;
  logic                                valid;
  logic                                ready;
  logic [pec_pkg::WL_W-1:0]            wavelength;
  logic signed [pec_pkg::INT_W-1:0]    intensity_pp;
  logic signed [pec_pkg::INT_W-1:0]    intensity_aa;
  logic signed [pec_pkg::INT_W-1:0]    intensity_pa;
  logic signed [pec_pkg::INT_W-1:0]    intensity_ap;

  modport source (output valid, wavelength, intensity_pp, intensity_aa,
                  intensity_pa, intensity_ap, input ready);
  modport sink   (input valid, wavelength, intensity_pp, intensity_aa,
                  intensity_pa, intensity_ap, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pec_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_out_if: corrected bin channel
// Four corrected intensities and a status code, valid/ready transfer.
// ----------------------------------------------------------------------------
interface pec_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pec_pkg::INT_W-1:0]    corrected_pp;
  logic signed [pec_pkg::INT_W-1:0]    corrected_aa;
  logic signed [pec_pkg::INT_W-1:0]    corrected_pa;
  logic signed [pec_pkg::INT_W-1:0]    corrected_ap;
  logic [pec_pkg::ST_W-1:0]            status;

  modport source (output valid, corrected_pp, corrected_aa, corrected_pa,
                  corrected_ap, status, input ready);
  modport sink   (input valid, corrected_pp, corrected_aa, corrected_pa,
                  corrected_ap, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pec_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_cfg: configuration register bank
// APB-style write/read of the mode and the four coefficient registers.
// ----------------------------------------------------------------------------
module pec_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pec_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pec_pkg::DATA_W-1:0]   pwdata,
  output logic      [pec_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output pec_pkg::cfg_t                     cfg
);

  pec_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[pec_pkg::ADDR_W-1:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refl <= 1'b0;
      for (int k = 0; k < pec_pkg::NCH; k++) begin
        cfg_r.coef[k] <= pec_pkg::COEF_RESET;
      end
    end else if (wr) begin
      case (idx)
        pec_pkg::REG_MODE:  cfg_r.refl <= pwdata[0];
        pec_pkg::REG_RHO:   cfg_r.coef[pec_pkg::E_RHO]   <= pwdata[pec_pkg::CREG_W-1:0];
        pec_pkg::REG_PP:    cfg_r.coef[pec_pkg::E_PP]    <= pwdata[pec_pkg::CREG_W-1:0];
        pec_pkg::REG_ALPHA: cfg_r.coef[pec_pkg::E_ALPHA] <= pwdata[pec_pkg::CREG_W-1:0];
        pec_pkg::REG_AP:    cfg_r.coef[pec_pkg::E_AP]    <= pwdata[pec_pkg::CREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pec_pkg::REG_MODE:  prdata = {{(pec_pkg::DATA_W-1){1'b0}}, cfg_r.refl};
      pec_pkg::REG_RHO:   prdata = {1'b0, cfg_r.coef[pec_pkg::E_RHO]};
      pec_pkg::REG_PP:    prdata = {1'b0, cfg_r.coef[pec_pkg::E_PP]};
      pec_pkg::REG_ALPHA: prdata = {1'b0, cfg_r.coef[pec_pkg::E_ALPHA]};
      pec_pkg::REG_AP:    prdata = {1'b0, cfg_r.coef[pec_pkg::E_AP]};
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/pec_eff.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_eff: efficiency polynomial pipeline
// Horner evaluation in four stages, saturated to Q2.19 with a flag.
// ----------------------------------------------------------------------------
module pec_eff #(
  parameter int POLY_TERMS = pec_pkg::POLY_TERMS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              adv,
  input  wire logic [pec_pkg::CREG_W-1:0]        coef,
  input  wire logic [pec_pkg::WL_W-1:0]          x,
  output logic signed [pec_pkg::EFF_W-1:0]       eff,
  output logic                                   sat
);

  localparam int CW = pec_pkg::COEF_W;

  logic signed [CW-1:0] c0, c1, c2;
  // unused high terms read as zero, which leaves Horner's result unchanged
  assign c2 = (POLY_TERMS > 2) ? $signed(coef[2*CW +: CW]) : '0;
  assign c1 = (POLY_TERMS > 1) ? $signed(coef[CW +: CW]) : '0;
  assign c0 = $signed(coef[0 +: CW]);

  logic signed [45:0] p1_r, r1;
  logic signed [27:0] acc1_r;
  logic signed [52:0] p2_r, r2;
  logic signed [35:0] s2;
  logic [pec_pkg::WL_W-1:0] x1_r, x2_r;
  logic signed [CW-1:0] eff_r;
  logic sat_r;

  always_comb begin
    r1 = (p1_r + 46'sd131072) >>> pec_pkg::WL_FRAC;
    r2 = (p2_r + 53'sd131072) >>> pec_pkg::WL_FRAC;
    s2 = $signed(r2[35:0]) + 36'(c0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= 46'(c2) * 46'($signed({1'b0, x}));
      x1_r   <= x;
      acc1_r <= $signed(r1[27:0]) + 28'(c1);
      x2_r   <= x1_r;
      p2_r   <= 53'(acc1_r) * 53'($signed({1'b0, x2_r}));
      if (s2 > 36'sd1048575) begin
        eff_r <= 21'sd1048575;
        sat_r <= 1'b1;
      end else if (s2 < -36'sd1048576) begin
        eff_r <= -21'sd1048576;
        sat_r <= 1'b1;
      end else begin
        eff_r <= $signed(s2[CW-1:0]);
        sat_r <= 1'b0;
      end
    end
  end

  assign eff = eff_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

// File: hw/rtl/pec_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_mix: efficiency mixing pipeline
// Efficiency products, divisor and the numerator weight matrix, four stages.
// ----------------------------------------------------------------------------
module pec_mix (
  input  wire logic                              clk,
  input  wire logic                              adv,
  input  wire logic                              refl,
  input  wire logic signed [pec_pkg::EFF_W-1:0]  eff_rho,
  input  wire logic signed [pec_pkg::EFF_W-1:0]  eff_pp,
  input  wire logic signed [pec_pkg::EFF_W-1:0]  eff_alpha,
  input  wire logic signed [pec_pkg::EFF_W-1:0]  eff_ap,
  input  wire logic                              sat_in,
  output logic signed [pec_pkg::MW-1:0]          mat [pec_pkg::NCH][pec_pkg::NCH],
  output logic signed [pec_pkg::MW-1:0]          den,
  output pec_pkg::side_t                         side
);

  localparam int W = pec_pkg::MW;
  localparam logic signed [W-1:0] ONE = pec_pkg::ONE;

  logic signed [W-1:0] r0, p0, a0, ap0, opr0;
  // stage 1
  logic signed [W-1:0] pa1_r, pr1_r, aa1_r, opr1_r, opa1_r, dr1_r, r1_r, a1_r, p1_r, ap1_r;
  // stage 2
  logic signed [W-1:0] par2_r, paa2_r, ra2_r, p2_r, ap2_r, pr2_r, aa2_r, pa2_r, a2_r, dr2_r;
  // stage 3
  logic signed [W-1:0] paar3_r, d3_r, p3_r, ap3_r, pr3_r, aa3_r, pa3_r, par3_r, paa3_r;
  // stage 4
  logic signed [W-1:0] mat_r [pec_pkg::NCH][pec_pkg::NCH];
  logic signed [W-1:0] mat_nxt [pec_pkg::NCH][pec_pkg::NCH];
  logic signed [W-1:0] d4_r;
  logic [2:0] sat_d_r;
  pec_pkg::side_t side_r;

  assign r0   = W'(eff_rho);
  assign p0   = W'(eff_pp);
  assign a0   = W'(eff_alpha);
  assign ap0  = W'(eff_ap);
  assign opr0 = ONE + r0;

  always_comb begin
    logic signed [W-1:0] prs, ps, ss;
    for (int o = 0; o < pec_pkg::NCH; o++) begin
      prs = o[0] ? -pr3_r : pr3_r;
      ps  = o[0] ? -p3_r : p3_r;
      ss  = o[1] ? -ONE : ONE;
      if (refl) begin
        mat_nxt[o][0] = '0;
        mat_nxt[o][1] = '0;
        if (o < 2) begin
          mat_nxt[o][0] = pr3_r + ss;
          mat_nxt[o][1] = p3_r - ss;
          if (o == 1) begin
            mat_nxt[o][0] = pr3_r - ONE;
            mat_nxt[o][1] = p3_r + ONE;
          end
        end
        mat_nxt[o][2] = '0;
        mat_nxt[o][3] = '0;
      end else begin
        mat_nxt[o][0] = paar3_r + aa3_r + prs + ss;
        mat_nxt[o][1] = pa3_r - ps - ap3_r + ss;
        mat_nxt[o][2] = par3_r + ap3_r - prs - ss;
        mat_nxt[o][3] = paa3_r + ps - aa3_r - ss;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa1_r  <= pec_pkg::mulq(p0, ap0);
      pr1_r  <= pec_pkg::mulq(p0, r0);
      aa1_r  <= pec_pkg::mulq(ap0, a0);
      opr1_r <= opr0;
      opa1_r <= ONE + a0;
      dr1_r  <= pec_pkg::mulq(p0, opr0);
      r1_r   <= r0;
      a1_r   <= a0;
      p1_r   <= p0;
      ap1_r  <= ap0;

      par2_r <= pec_pkg::mulq(pa1_r, r1_r);
      paa2_r <= pec_pkg::mulq(pa1_r, a1_r);
      ra2_r  <= pec_pkg::mulq(opr1_r, opa1_r);
      p2_r   <= p1_r;
      ap2_r  <= ap1_r;
      pr2_r  <= pr1_r;
      aa2_r  <= aa1_r;
      pa2_r  <= pa1_r;
      a2_r   <= a1_r;
      dr2_r  <= dr1_r;

      paar3_r <= pec_pkg::mulq(par2_r, a2_r);
      d3_r    <= refl ? dr2_r : pec_pkg::mulq(pa2_r, ra2_r);
      p3_r    <= p2_r;
      ap3_r   <= ap2_r;
      pr3_r   <= pr2_r;
      aa3_r   <= aa2_r;
      pa3_r   <= pa2_r;
      par3_r  <= par2_r;
      paa3_r  <= paa2_r;

      mat_r       <= mat_nxt;
      d4_r        <= d3_r;
      side_r.zero <= (d3_r == '0);
      side_r.sat  <= sat_d_r[2];
      sat_d_r     <= {sat_d_r[1:0], sat_in};
    end
  end

  assign mat  = mat_r;
  assign den  = d4_r;
  assign side = side_r;

endmodule
`default_nettype wire

// File: hw/rtl/pec_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pec_div: pipelined restoring divider lane
// One quotient bit per stage after an overflow check; carries the sign along.
// ----------------------------------------------------------------------------
module pec_div (
  input  wire logic                           clk,
  input  wire logic                           adv,
  input  wire logic [pec_pkg::NUM_W-1:0]      un,
  input  wire logic [pec_pkg::MW-1:0]         ud,
  input  wire logic                           neg,
  output logic [pec_pkg::QBITS-1:0]           q,
  output logic                                ovf,
  output logic                                neg_o
);

  localparam int NB = pec_pkg::QBITS;
  localparam int RW = pec_pkg::NUM_W;
  localparam int DW = pec_pkg::MW;

  logic [RW-1:0] rem_r [NB+1];
  logic [DW-1:0] ud_r  [NB+1];
  logic [NB-1:0] q_r   [NB+1];
  logic          ovf_r [NB+1];
  logic          neg_r [NB+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0] <= {1'b0, un} >= ({{(RW+1-DW){1'b0}}, ud} << NB);
      rem_r[0] <= un;
      ud_r[0]  <= ud;
      q_r[0]   <= '0;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_stage
    logic [RW:0] dsh;
    logic        ge;
    assign dsh = {{(RW+1-DW){1'b0}}, ud_r[k-1]} << (NB - k);
    assign ge  = {1'b0, rem_r[k-1]} >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? rem_r[k-1] - dsh[RW-1:0] : rem_r[k-1];
        q_r[k]   <= {q_r[k-1][NB-2:0], ge};
        ud_r[k]  <= ud_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign q     = q_r[NB];
  assign ovf   = ovf_r[NB];
  assign neg_o = neg_r[NB];

endmodule
`default_nettype wire

// File: hw/rtl/polarization_efficiency_correction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polarization_efficiency_correction: per-bin polarization efficiency fix-up
// Evaluates the four efficiency polynomials at the bin wavelength and returns
// the corrected intensities, with divide-by-zero and saturation status.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   bins in: wavelength (Q6.18) and four Q16.16 intensities. One
//           transfer per cycle is sustained while the output is not stalled.
//   out_if  corrected bins out, in input order, one per input transfer.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready: register port, register i
//           at byte address 8*i, written in the access cycle. Write only while
//           no bin is in flight.
//   An input transfer reaches the output valid through one input stage, four
//   polynomial stages, four mixing stages, product, sum and magnitude stages,
//   34 divider stages (overflow check plus one quotient bit per stage) and the
//   output register. Throughput is one bin per cycle unless the output stalls.
//   Reset clears the valid pipeline, the mode (full analysis) and sets each
//   coefficient register to a constant term of 1.0.
//   When the receiver stalls with a bin on the output, the whole pipeline
//   holds and in_if.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module polarization_efficiency_correction #(
  parameter int POLY_TERMS = pec_pkg::POLY_TERMS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  pec_in_if.sink                            in_if,
  pec_out_if.source                         out_if,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pec_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pec_pkg::DATA_W-1:0]   pwdata,
  output logic      [pec_pkg::DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int NCH = pec_pkg::NCH;
  localparam int IW  = pec_pkg::INT_W;
  localparam int W   = pec_pkg::MW;
  localparam int NW  = pec_pkg::NUM_W;
  localparam int ND  = pec_pkg::PIPE_DEPTH;

  pec_pkg::cfg_t cfg;

  pec_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  // --- pipeline control: every stage advances together -----------------------
  logic [ND-1:0] v_r;
  logic          adv;

  // advance whenever the output register is empty or being drained
  assign adv         = ~v_r[ND-1] | out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[ND-2:0], in_if.valid};
    end
  end

  // --- input stage and intensity delay line -----------------------------------
  logic [pec_pkg::WL_W-1:0] x0_r;
  logic signed [IW-1:0]     ipipe_r [pec_pkg::IDLY+1][NCH];

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r          <= in_if.wavelength;
      ipipe_r[0][0] <= in_if.intensity_pp;
      ipipe_r[0][1] <= in_if.intensity_aa;
      ipipe_r[0][2] <= in_if.intensity_pa;
      ipipe_r[0][3] <= in_if.intensity_ap;
      for (int d = 1; d <= pec_pkg::IDLY; d++) begin
        ipipe_r[d] <= ipipe_r[d-1];
      end
    end
  end

  // --- efficiency polynomials --------------------------------------------------
  logic signed [pec_pkg::EFF_W-1:0] eff [NCH];
  logic [NCH-1:0]                   eff_sat;
  logic                             sat_eff;

  for (genvar e = 0; e < NCH; e++) begin : g_eff
    pec_eff #(.POLY_TERMS(POLY_TERMS)) u_eff (
      .clk, .adv, .coef(cfg.coef[e]), .x(x0_r), .eff(eff[e]), .sat(eff_sat[e])
    );
  end

  // analyzer terms only count in full analysis
  assign sat_eff = eff_sat[pec_pkg::E_RHO] | eff_sat[pec_pkg::E_PP] |
                   (~cfg.refl & (eff_sat[pec_pkg::E_ALPHA] | eff_sat[pec_pkg::E_AP]));

  // --- mixing: divisor and numerator weights ----------------------------------
  logic signed [W-1:0] mat [NCH][NCH];
  logic signed [W-1:0] den;
  pec_pkg::side_t      side_m;

  pec_mix u_mix (
    .clk, .adv, .refl(cfg.refl),
    .eff_rho(eff[pec_pkg::E_RHO]), .eff_pp(eff[pec_pkg::E_PP]),
    .eff_alpha(eff[pec_pkg::E_ALPHA]), .eff_ap(eff[pec_pkg::E_AP]),
    .sat_in(sat_eff), .mat, .den, .side(side_m)
  );

  // --- numerators: products, sum, magnitudes -----------------------------------
  logic signed [NW-1:0] prod_r [NCH][NCH];
  logic signed [NW-1:0] num_r  [NCH];
  logic signed [W-1:0]  den1_r, den2_r;
  logic [NW-1:0]        un_r  [NCH];
  logic                 neg_r [NCH];
  logic [W-1:0]         ud_r;
  logic [W-1:0]         ud_c;

  assign ud_c = den2_r[W-1] ? W'(-den2_r) : den2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < NCH; o++) begin
        for (int j = 0; j < NCH; j++) begin
          prod_r[o][j] <= NW'(mat[o][j]) * NW'(ipipe_r[pec_pkg::IDLY][j]);
        end
        num_r[o] <= prod_r[o][0] + prod_r[o][1] + prod_r[o][2] + prod_r[o][3];
        // round to nearest: add half the divisor to the magnitude
        un_r[o]  <= (num_r[o][NW-1] ? NW'(-num_r[o]) : num_r[o]) +
                    {{(NW-W+1){1'b0}}, ud_c[W-1:1]};
        neg_r[o] <= num_r[o][NW-1] ^ den2_r[W-1];
      end
      den1_r <= den;
      den2_r <= den1_r;
      ud_r   <= ud_c;
    end
  end

  // --- dividers ---------------------------------------------------------------
  logic [pec_pkg::QBITS-1:0] q     [NCH];
  logic [NCH-1:0]            q_ovf;
  logic [NCH-1:0]            q_neg;

  for (genvar o = 0; o < NCH; o++) begin : g_div
    pec_div u_div (
      .clk, .adv, .un(un_r[o]), .ud(ud_r), .neg(neg_r[o]),
      .q(q[o]), .ovf(q_ovf[o]), .neg_o(q_neg[o])
    );
  end

  // --- status side line, matched to the divider latency ------------------------
  pec_pkg::side_t side_r [pec_pkg::SIDE_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_m;
      for (int d = 1; d < pec_pkg::SIDE_LAT; d++) begin
        side_r[d] <= side_r[d-1];
      end
    end
  end

  // --- sign, clamp and output register ---------------------------------------
  logic signed [IW-1:0] val  [NCH];
  logic [NCH-1:0]       lsat;
  logic signed [IW-1:0] res_r [NCH];
  logic [pec_pkg::ST_W-1:0] status_r;
  pec_pkg::side_t       side_l;

  assign side_l = side_r[pec_pkg::SIDE_LAT-1];

  always_comb begin
    for (int o = 0; o < NCH; o++) begin
      if (q_neg[o]) begin
        lsat[o] = q_ovf[o] | (q[o] > 33'h080000000);
        val[o]  = lsat[o] ? 32'sh80000000 : $signed(32'd0 - q[o][IW-1:0]);
      end else begin
        lsat[o] = q_ovf[o] | (q[o] > 33'h07FFFFFFF);
        val[o]  = lsat[o] ? 32'sh7FFFFFFF : $signed(q[o][IW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int o = 0; o < NCH; o++) begin
        res_r[o] <= side_l.zero ? '0 : val[o];
      end
      if (side_l.zero) begin
        status_r <= pec_pkg::ST_ZERO;
      end else if (side_l.sat | (|lsat)) begin
        status_r <= pec_pkg::ST_SAT;
      end else begin
        status_r <= pec_pkg::ST_OK;
      end
    end
  end

  assign out_if.valid        = v_r[ND-1];
  assign out_if.corrected_pp = res_r[0];
  assign out_if.corrected_aa = res_r[1];
  assign out_if.corrected_pa = res_r[2];
  assign out_if.corrected_ap = res_r[3];
  assign out_if.status       = status_r;

endmodule
`default_nettype wire
